// ===== rtl/core/arkp_pkg.sv =====
// constants shared by the aspect-ratio keyword parser
`default_nettype none

package arkp_pkg;

	// default token store depth
	localparam int ARKP_TOKEN_CHARS = 8;

	// command codes
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// grammar phases
	localparam logic [2:0] PH_DEFER     = 3'd0;
	localparam logic [2:0] PH_ALIGN     = 3'd1;
	localparam logic [2:0] PH_MEETSLICE = 3'd2;
	localparam logic [2:0] PH_DONE      = 3'd3;
	localparam logic [2:0] PH_ERROR     = 3'd4;

	// alignment codes
	localparam logic [1:0] POS_NONE = 2'd0;
	localparam logic [1:0] POS_MIN  = 2'd1;
	localparam logic [1:0] POS_MID  = 2'd2;
	localparam logic [1:0] POS_MAX  = 2'd3;

	// scale modes
	localparam logic [1:0] SCALE_FILL = 2'd0;
	localparam logic [1:0] SCALE_FIT  = 2'd1;
	localparam logic [1:0] SCALE_CROP = 2'd2;

	// separator characters
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;

	// keywords, first character in the top byte
	localparam logic [39:0] KW_DEFER = "defer";
	localparam logic [39:0] KW_SLICE = "slice";
	localparam logic [31:0] KW_NONE  = "none";
	localparam logic [31:0] KW_MEET  = "meet";
	localparam logic [31:0] KW_XMIN  = "xMin";
	localparam logic [31:0] KW_XMID  = "xMid";
	localparam logic [31:0] KW_XMAX  = "xMax";
	localparam logic [31:0] KW_YMIN  = "YMin";
	localparam logic [31:0] KW_YMID  = "YMid";
	localparam logic [31:0] KW_YMAX  = "YMax";

endpackage

`default_nettype wire

// ===== rtl/core/aspect_ratio_keyword_parser.sv =====
// aspect-ratio attribute parser: character stream in, alignment and scale result out
`default_nettype none

// channel | signals                                   | direction | moves
// --------+-------------------------------------------+-----------+------------------------------
// in      | in_valid, in_stall, command, char_code    | into block| one character or end word
// out     | out_valid, out_stall, align_x, align_y,   | out of    | one result word per end word
//         | meet_flag, scale_mode, parse_failed       | block     |
//
// one input word is taken every cycle unless in_stall is raised; each word is registered, then the token
// store, length count and grammar phase update as the word moves on from that register
// an end word is registered in the input stage, then its result in the result register that drives the out channel
// out_stall backs up into in_stall only when an end word meets a held result;
// character words keep flowing while a result waits
// reset clears the phase, length, held values and both valid flags; the
// character store is not cleared, the length count hides stale entries

module aspect_ratio_keyword_parser
	import arkp_pkg::*;
#(
	// must be at least 8 so the two-part alignment word fits
	parameter int TOKEN_CHARS = ARKP_TOKEN_CHARS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       command,
	input  wire logic [7:0] char_code,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      align_x,
	output logic [1:0]      align_y,
	output logic            meet_flag,
	output logic [1:0]      scale_mode,
	output logic            parse_failed
);

	// length saturates at TOKEN_CHARS + 1
	localparam int LEN_W = $clog2(TOKEN_CHARS + 2);

	// input register stage
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] char_s1;

	// parser state
	logic [2:0]       phase_q;
	logic [LEN_W-1:0] len_q;
	logic [1:0]       held_x_q;
	logic [1:0]       held_y_q;
	logic             held_meet_q;
	logic [7:0]       chars_q [TOKEN_CHARS];

	// result register
	logic       out_valid_q;
	logic [1:0] align_x_q;
	logic [1:0] align_y_q;
	logic       meet_q;
	logic [1:0] scale_q;
	logic       failed_q;

	logic in_accept;
	logic drain;
	logic is_end;
	logic is_sep;

	// token decode
	logic [39:0] head5;
	logic [31:0] head4;
	logic [31:0] tail4;
	logic        tok_defer;
	logic        tok_none;
	logic        tok_meet;
	logic        tok_slice;
	logic [1:0]  word_x;
	logic [1:0]  word_y;
	logic        word_ok;

	// state after closing the current token
	logic [2:0] cl_phase;
	logic [1:0] cl_x;
	logic [1:0] cl_y;
	logic       cl_meet;

	// the s1 word moves on unless it is an end word facing a held result
	assign is_end    = (command_s1 == CMD_END);
	assign drain     = valid_s1 && (!is_end || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !drain;
	assign in_accept = in_valid && !in_stall;

	assign is_sep = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB) || (char_s1 == CH_NEWLINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			command_s1 <= command;
			char_s1    <= char_code;
		end
	end

	// fixed-place views of the token store
	assign head5 = {chars_q[0], chars_q[1], chars_q[2], chars_q[3], chars_q[4]};
	assign head4 = {chars_q[0], chars_q[1], chars_q[2], chars_q[3]};
	assign tail4 = {chars_q[4], chars_q[5], chars_q[6], chars_q[7]};

	assign tok_defer = (len_q == LEN_W'(5)) && (head5 == KW_DEFER);
	assign tok_slice = (len_q == LEN_W'(5)) && (head5 == KW_SLICE);
	assign tok_none  = (len_q == LEN_W'(4)) && (head4 == KW_NONE);
	assign tok_meet  = (len_q == LEN_W'(4)) && (head4 == KW_MEET);

	always_comb begin
		case (head4)
			KW_XMIN: word_x = POS_MIN;
			KW_XMID: word_x = POS_MID;
			KW_XMAX: word_x = POS_MAX;
			default: word_x = POS_NONE;
		endcase
		case (tail4)
			KW_YMIN: word_y = POS_MIN;
			KW_YMID: word_y = POS_MID;
			KW_YMAX: word_y = POS_MAX;
			default: word_y = POS_NONE;
		endcase
	end

	assign word_ok = (len_q == LEN_W'(8)) && (word_x != POS_NONE) && (word_y != POS_NONE);

	// grammar step for the token that a separator or end word closes
	always_comb begin
		cl_phase = phase_q;
		cl_x     = held_x_q;
		cl_y     = held_y_q;
		cl_meet  = held_meet_q;
		if (len_q != '0) begin
			case (phase_q)
				PH_DEFER, PH_ALIGN: begin
					if (phase_q == PH_DEFER && tok_defer) begin
						cl_phase = PH_ALIGN;
					end else if (tok_none) begin
						cl_x     = POS_NONE;
						cl_y     = POS_NONE;
						cl_phase = PH_MEETSLICE;
					end else if (word_ok) begin
						cl_x     = word_x;
						cl_y     = word_y;
						cl_phase = PH_MEETSLICE;
					end else begin
						cl_phase = PH_ERROR;
					end
				end
				PH_MEETSLICE: begin
					if (tok_meet) begin
						cl_meet  = 1'b1;
						cl_phase = PH_DONE;
					end else if (tok_slice) begin
						cl_meet  = 1'b0;
						cl_phase = PH_DONE;
					end else begin
						cl_phase = PH_ERROR;
					end
				end
				default: begin
					cl_phase = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DEFER;
			len_q       <= '0;
			held_x_q    <= POS_NONE;
			held_y_q    <= POS_NONE;
			held_meet_q <= 1'b1;
		end else if (drain) begin
			if (is_end) begin
				// string finished: back to the start for the next one
				phase_q     <= PH_DEFER;
				len_q       <= '0;
				held_x_q    <= POS_NONE;
				held_y_q    <= POS_NONE;
				held_meet_q <= 1'b1;
			end else if (is_sep) begin
				phase_q     <= cl_phase;
				len_q       <= '0;
				held_x_q    <= cl_x;
				held_y_q    <= cl_y;
				held_meet_q <= cl_meet;
			end else if (len_q <= LEN_W'(TOKEN_CHARS)) begin
				len_q <= len_q + LEN_W'(1);
			end
		end
	end

	// character store, one write place per entry
	for (genvar gi = 0; gi < TOKEN_CHARS; gi++) begin : g_store
		always_ff @(posedge clk) begin
			if (drain && !is_end && !is_sep && len_q == LEN_W'(gi)) begin
				chars_q[gi] <= char_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain && is_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// malformed strings report the defaults with the failure flag
	always_ff @(posedge clk) begin
		if (drain && is_end) begin
			if (cl_phase == PH_ERROR) begin
				align_x_q <= POS_NONE;
				align_y_q <= POS_NONE;
				meet_q    <= 1'b1;
				scale_q   <= SCALE_FILL;
				failed_q  <= 1'b1;
			end else begin
				align_x_q <= cl_x;
				align_y_q <= cl_y;
				meet_q    <= cl_meet;
				failed_q  <= 1'b0;
				if (cl_x == POS_NONE && cl_y == POS_NONE) begin
					scale_q <= SCALE_FILL;
				end else if (cl_meet) begin
					scale_q <= SCALE_FIT;
				end else begin
					scale_q <= SCALE_CROP;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign align_x      = align_x_q;
	assign align_y      = align_y_q;
	assign meet_flag    = meet_q;
	assign scale_mode   = scale_q;
	assign parse_failed = failed_q;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the aspect-ratio keyword parser
`timescale 1ns / 1ps

module testbench;
	import arkp_pkg::*;

	localparam int TOK_DEPTH    = ARKP_TOKEN_CHARS;
	localparam int QUIET_LIMIT  = 1000;   // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 8;      // extra wait once every owed result has been checked

	// one result word, as the out channel carries it
	typedef struct packed {
		logic [1:0] align_x;
		logic [1:0] align_y;
		logic       meet;
		logic [1:0] mode;
		logic       failed;
	} parse_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       command = CMD_CHAR;
	logic [7:0] char_code = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] align_x;
	logic [1:0] align_y;
	logic       meet_flag;
	logic [1:0] scale_mode;
	logic       parse_failed;

	// handshake pressure, percent per cycle
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// bookkeeping
	int error_count = 0;
	int items_sent = 0;
	int strings_sent = 0;
	int results_checked = 0;
	int malformed_seen = 0;
	int quiet_cycles = 0;

	// results owed by the block, oldest first
	parse_result_t pending_results[$];

	// characters of the attribute string being built
	logic [7:0] line_chars[$];

	// alignment halves used to build two-part words
	logic [31:0] x_words[3] = '{KW_XMIN, KW_XMID, KW_XMAX};
	logic [31:0] y_words[3] = '{KW_YMIN, KW_YMID, KW_YMAX};

	// shadow of the parser state
	logic [2:0] parse_phase;
	logic [7:0] tok_buf[TOK_DEPTH];
	int         tok_len;
	logic [1:0] keep_x;
	logic [1:0] keep_y;
	logic       keep_meet;

	aspect_ratio_keyword_parser #(
		.TOKEN_CHARS(TOK_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.align_x     (align_x),
		.align_y     (align_y),
		.meet_flag   (meet_flag),
		.scale_mode  (scale_mode),
		.parse_failed(parse_failed)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// shadow parser
	// ------------------------------------------------------------------

	function automatic bit is_sep(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_NEWLINE;
	endfunction

	function automatic void parser_clear();
		parse_phase = PH_DEFER;
		tok_len     = 0;
		keep_x      = POS_NONE;
		keep_y      = POS_NONE;
		keep_meet   = 1'b1;
	endfunction

	// n keyword characters, first one in the top byte, sit in the store at off
	function automatic bit chars_match(input int off, input logic [63:0] kw, input int n);
		for (int i = 0; i < n; i++) begin
			if (tok_buf[off + i] != kw[8 * (n - 1 - i) +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit token_is(input logic [63:0] kw, input int n);
		return tok_len == n && chars_match(0, kw, n);
	endfunction

	function automatic logic [1:0] align_part(input int off, input logic [31:0] k_min,
			input logic [31:0] k_mid, input logic [31:0] k_max);
		if (chars_match(off, k_min, 4))
			return POS_MIN;
		if (chars_match(off, k_mid, 4))
			return POS_MID;
		if (chars_match(off, k_max, 4))
			return POS_MAX;
		return POS_NONE;
	endfunction

	function automatic void take_align();
		logic [1:0] ax;
		logic [1:0] ay;
		if (token_is(KW_NONE, 4)) begin
			keep_x      = POS_NONE;
			keep_y      = POS_NONE;
			parse_phase = PH_MEETSLICE;
		end else if (tok_len == 8) begin
			// only a full eight-character token reaches here, so every position is written
			ax = align_part(0, KW_XMIN, KW_XMID, KW_XMAX);
			ay = align_part(4, KW_YMIN, KW_YMID, KW_YMAX);
			if (ax == POS_NONE || ay == POS_NONE) begin
				parse_phase = PH_ERROR;
			end else begin
				keep_x      = ax;
				keep_y      = ay;
				parse_phase = PH_MEETSLICE;
			end
		end else begin
			parse_phase = PH_ERROR;
		end
	endfunction

	function automatic void close_token();
		if (tok_len == 0)
			return;
		case (parse_phase)
			PH_DEFER: begin
				if (token_is(KW_DEFER, 5))
					parse_phase = PH_ALIGN;
				else
					take_align();
			end
			PH_ALIGN: begin
				take_align();
			end
			PH_MEETSLICE: begin
				if (token_is(KW_MEET, 4)) begin
					keep_meet   = 1'b1;
					parse_phase = PH_DONE;
				end else if (token_is(KW_SLICE, 5)) begin
					keep_meet   = 1'b0;
					parse_phase = PH_DONE;
				end else begin
					parse_phase = PH_ERROR;
				end
			end
			default: begin
				// done or error: extra tokens are ignored
			end
		endcase
		tok_len = 0;
	endfunction

	// advance the shadow by one taken word; returns 1 when a result is owed
	function automatic bit parse_word(input logic cmd, input logic [7:0] ch,
			output parse_result_t res);
		res = '0;
		if (cmd == CMD_CHAR) begin
			if (is_sep(ch)) begin
				close_token();
			end else begin
				// overlong tokens stop storing and pin the length one past the store
				if (tok_len < TOK_DEPTH)
					tok_buf[tok_len] = ch;
				if (tok_len <= TOK_DEPTH)
					tok_len++;
			end
			return 1'b0;
		end
		close_token();
		if (parse_phase == PH_ERROR) begin
			res = '{POS_NONE, POS_NONE, 1'b1, SCALE_FILL, 1'b1};
		end else begin
			res.align_x = keep_x;
			res.align_y = keep_y;
			res.meet    = keep_meet;
			if (keep_x == POS_NONE && keep_y == POS_NONE)
				res.mode = SCALE_FILL;
			else
				res.mode = keep_meet ? SCALE_FIT : SCALE_CROP;
			res.failed = 1'b0;
		end
		parser_clear();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// string builders
	// ------------------------------------------------------------------

	function automatic logic [7:0] sep_char();
		case ($urandom_range(2))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			default: return CH_NEWLINE;
		endcase
	endfunction

	function automatic logic [7:0] token_char();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(255));
		while (is_sep(ch));
		return ch;
	endfunction

	function automatic void push_seps(input int lo, input int hi);
		repeat ($urandom_range(hi, lo))
			line_chars.push_back(sep_char());
	endfunction

	// append a keyword, one character replaced by a random byte now and then
	function automatic void push_word(input logic [63:0] kw, input int n, input int corrupt_pct);
		int bad;
		bad = ($urandom_range(99) < corrupt_pct) ? int'($urandom_range(n - 1)) : -1;
		for (int i = 0; i < n; i++)
			line_chars.push_back(i == bad ? 8'($urandom_range(255)) : kw[8 * (n - 1 - i) +: 8]);
	endfunction

	function automatic void push_garbage(input int max_len);
		repeat ($urandom_range(max_len, 1))
			line_chars.push_back(token_char());
	endfunction

	// mostly well-formed strings with random content, some noise
	function automatic void build_random_string();
		int slot;
		line_chars.delete();
		if ($urandom_range(9) == 0) begin
			// raw bytes, separators included
			repeat ($urandom_range(12, 1))
				line_chars.push_back(8'($urandom_range(255)));
			return;
		end
		push_seps(0, 2);
		if ($urandom_range(1))
			begin
				push_word(KW_DEFER, 5, 10);
				push_seps(1, 2);
			end
		slot = $urandom_range(9);
		case (slot)
			0: return;    // ends before the alignment
			1: push_word(KW_NONE, 4, 10);
			2: push_garbage(10);
			3: begin
				// alignment word with extra characters: longer than the store
				push_word({x_words[$urandom_range(2)], y_words[$urandom_range(2)]}, 8, 0);
				push_garbage(3);
			end
			default: push_word({x_words[$urandom_range(2)], y_words[$urandom_range(2)]}, 8, 10);
		endcase
		if ($urandom_range(5) == 0)
			return;       // ends before meet or slice
		// an occasional missing separator glues two tokens together
		push_seps($urandom_range(19) == 0 ? 0 : 1, 2);
		case ($urandom_range(9))
			0, 1, 2, 3: push_word(KW_MEET, 4, 10);
			4, 5, 6, 7: push_word(KW_SLICE, 5, 10);
			8:          push_garbage(6);
			default:    push_word(KW_DEFER, 5, 0);
		endcase
		// trailing tokens are ignored, whether the string is done or in error
		repeat ($urandom_range(2)) begin
			push_seps(1, 2);
			if ($urandom_range(1))
				push_word(KW_NONE, 4, 0);
			else
				push_garbage(10);
		end
		push_seps(0, 1);
	endfunction

	// ------------------------------------------------------------------
	// in channel
	// ------------------------------------------------------------------

	// present one word at the falling edge and hold it until it is taken
	task automatic send_word(input logic cmd, input logic [7:0] ch);
		parse_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		char_code <= ch;
		do
			@(posedge clk);
		while (in_stall);
		items_sent++;
		if (parse_word(cmd, ch, res))
			pending_results.push_back(res);
	endtask

	// the built characters, then an end word carrying a random don't-care byte
	task automatic send_string();
		foreach (line_chars[i])
			send_word(CMD_CHAR, line_chars[i]);
		send_word(CMD_END, 8'($urandom_range(255)));
		strings_sent++;
	endtask

	// ------------------------------------------------------------------
	// out channel
	// ------------------------------------------------------------------

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		parse_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t ns: result with nothing owed, expected none, got %0d/%0d/%0d/%0d/%0d",
					$time, align_x, align_y, meet_flag, scale_mode, parse_failed);
			end else begin
				want = pending_results.pop_front();
				check_field("align_x", int'(want.align_x), int'(align_x));
				check_field("align_y", int'(want.align_y), int'(align_y));
				check_field("meet_flag", int'(want.meet), int'(meet_flag));
				check_field("scale_mode", int'(want.mode), int'(scale_mode));
				check_field("parse_failed", int'(want.failed), int'(parse_failed));
				results_checked++;
				if (want.failed)
					malformed_seen++;
			end
		end
	end

	// watchdog: too long with nothing moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// end word alone: defaults, no error
	task automatic test_empty_string();
		line_chars.delete();
		send_string();
	endtask

	// lowest and highest codes are ordinary token characters; a two-char token is malformed
	task automatic test_extreme_codes();
		line_chars = '{8'h00, 8'hff};
		send_string();
	endtask

	// full alignment word, tab, slice
	task automatic test_crop_alignment();
		line_chars.delete();
		push_word({KW_XMID, KW_YMAX}, 8, 0);
		line_chars.push_back(CH_TAB);
		push_word(KW_SLICE, 5, 0);
		send_string();
	endtask

	// none with no meet or slice: short string, fill mode
	task automatic test_fill_default();
		line_chars.delete();
		push_word(KW_NONE, 4, 0);
		send_string();
	endtask

	task automatic test_random_strings(input int word_budget, input int send_pct,
			input int stall_pct);
		int stop_at;
		stop_at        = items_sent + word_budget;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		while (items_sent < stop_at) begin
			build_random_string();
			send_string();
		end
	endtask

	initial begin
		parser_clear();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed words with no pressure
		test_empty_string();
		test_extreme_codes();
		test_crop_alignment();
		test_fill_default();

		// random strings: free flow, sender gaps, receiver stalls, light mix
		test_random_strings(480, 0, 0);
		test_random_strings(480, 50, 0);
		test_random_strings(480, 0, 50);
		test_random_strings(480, 8, 8);

		// drop valid, then let every owed result come out
		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words in %0d strings across four handshake pressure mixes",
			items_sent, strings_sent);
		$display("compared %0d results, %0d of them flagged malformed",
			results_checked, malformed_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== aspect_ratio_keyword_parser.f =====
rtl/core/arkp_pkg.sv
rtl/core/aspect_ratio_keyword_parser.sv
dv/testbench.sv
